// ===== hw/rtl/double_hash_key_set_macros.svh =====
// Assertion macros for the key set.
`ifndef DOUBLE_HASH_KEY_SET_MACROS_SVH
`define DOUBLE_HASH_KEY_SET_MACROS_SVH
`define DHKS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DHKS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hw/rtl/dhks_pkg.sv =====
package dhks_pkg;
  localparam int unsigned CapacityLog2Def = 10;
  localparam int unsigned MaxKeyBytesDef = 8;
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] OUT_OK = 2'd0;
  localparam logic [1:0] OUT_FAIL = 2'd1;
  localparam logic [1:0] OUT_FULL = 2'd2;
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic probe_rd;
    logic advance;
    logic wr_live;
    logic wr_tomb;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic is_empty;
    logic is_match;
    logic have_tomb;
    logic probes_done;
    logic at_full;
    logic clr_done;
  } sts_t;
endpackage

// ===== hw/rtl/dhks_ram.sv =====
module dhks_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/dhks_datapath.sv =====
module dhks_datapath import dhks_pkg::*; #(
  parameter int unsigned CapacityLog2 = CapacityLog2Def,
  parameter int unsigned MaxKeyBytes = MaxKeyBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  input  logic [3:0]  size_log2_i
);
  localparam int unsigned Depth = 1 << CapacityLog2;
  localparam int unsigned AW = CapacityLog2;
  localparam logic [3:0] MaxLen = 4'(MaxKeyBytes);

  logic [63:0]   key_q, key_d;
  logic [3:0]    len_q, len_d;
  logic [3:0]    bi_q;
  logic [AW-1:0] h1_q, h2_q, pos_q, tomb_pos_q, step_w, mask_w, addr_w, waddr_w, clr_q;
  logic [AW:0]   cnt_q, size_w;
  logic          have_tomb_q, clr_busy_q;
  logic [AW:0]   live_q;
  logic [1:0]    mark_rd;
  logic [67:0]   kl_rd;
  logic [1:0]    mark_wd;
  logic          mark_we, kl_we;
  logic [3:0]    sl;
  logic [7:0]    byte_w;

  always_comb begin
    sl = size_log2_i;
    if (sl < 4'd3) sl = 4'd3;
    if (sl > 4'(CapacityLog2)) sl = 4'(CapacityLog2);
    size_w = (AW+1)'(1) << sl;
    mask_w = AW'(size_w - 1'b1);
    len_d = (key_length_i > MaxLen) ? MaxLen : key_length_i;
    key_d = key_bytes_i;
    if (len_d < 4'd8) key_d = key_bytes_i & ((64'd1 << {len_d, 3'b000}) - 64'd1);
    step_w = AW'({h2_q, 1'b1}) & mask_w;
    byte_w = key_q[{bi_q[2:0], 3'b000} +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      clr_busy_q <= 1'b1;
      clr_q <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) clr_busy_q <= 1'b0;
      end
      if (cmd_i.wr_live) live_q <= live_q + 1'b1;
      else if (cmd_i.wr_tomb && live_q != '0) live_q <= live_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_d;
      len_q <= len_d;
      bi_q <= '0;
      h1_q <= '0;
      h2_q <= '0;
      pos_q <= '0;
      have_tomb_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      h1_q <= AW'(h1_q * 17 + byte_w) & mask_w;
      h2_q <= AW'(h2_q * 73 + byte_w) & mask_w;
      bi_q <= bi_q + 1'b1;
      pos_q <= AW'(h1_q * 17 + byte_w) & mask_w;
    end else if (cmd_i.advance) begin
      if (mark_rd == MARK_TOMB && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
        tomb_pos_q <= pos_q;
      end
      pos_q <= (pos_q + step_w) & mask_w;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign addr_w = (cmd_i.probe_rd || cmd_i.advance) ? pos_q : pos_q;
  assign waddr_w = clr_busy_q ? clr_q :
                   (cmd_i.wr_live && have_tomb_q) ? tomb_pos_q : pos_q;
  assign mark_we = clr_busy_q || cmd_i.wr_live || cmd_i.wr_tomb;
  assign mark_wd = clr_busy_q ? MARK_EMPTY : (cmd_i.wr_live ? MARK_LIVE : MARK_TOMB);
  assign kl_we = cmd_i.wr_live;

  dhks_ram #(.Width(2), .Depth(Depth)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(waddr_w), .wdata_i(mark_wd),
    .raddr_i(addr_w), .rdata_o(mark_rd));
  dhks_ram #(.Width(68), .Depth(Depth)) u_kl (
    .clk_i, .we_i(kl_we), .waddr_i(waddr_w), .wdata_i({len_q, key_q}),
    .raddr_i(addr_w), .rdata_o(kl_rd));

  always_comb begin
    sts_o.hash_done = (bi_q >= len_q);
    sts_o.is_empty = (mark_rd == MARK_EMPTY);
    sts_o.is_match = (mark_rd == MARK_LIVE) && (kl_rd == {len_q, key_q});
    sts_o.have_tomb = have_tomb_q;
    sts_o.probes_done = (cnt_q >= size_w);
    sts_o.at_full = ({live_q, 2'b00} >= (AW+3)'(size_w * 3));
    sts_o.clr_done = !clr_busy_q;
  end
endmodule

// ===== hw/rtl/dhks_ctrl.sv =====
`include "double_hash_key_set_macros.svh"
module dhks_ctrl import dhks_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] outcome_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] kind_q, res_q, res_d, out_q;
  logic       ov_q, ov_d;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.clr_done;
  assign out_valid_o = ov_q;
  assign outcome_o = out_q;

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (kind_q == KIND_NONE) begin
          res_d = OUT_FAIL; state_d = S_DONE;
        end else if (kind_q == KIND_ADD && sts_i.at_full) begin
          res_d = OUT_FULL; state_d = S_DONE;
        end else if (sts_i.hash_done) begin
          state_d = S_READ;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_READ: begin
        if (sts_i.probes_done) begin
          if (kind_q == KIND_ADD) begin
            if (sts_i.have_tomb) begin
              cmd_o.wr_live = 1'b1; res_d = OUT_OK;
            end else begin
              res_d = OUT_FULL;
            end
          end else begin
            res_d = OUT_FAIL;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.probe_rd = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_DONE;
        if (sts_i.is_empty) begin
          if (kind_q == KIND_ADD) begin
            cmd_o.wr_live = 1'b1; res_d = OUT_OK;
          end else begin
            res_d = OUT_FAIL;
          end
        end else if (sts_i.is_match) begin
          if (kind_q == KIND_REMOVE) cmd_o.wr_tomb = 1'b1;
          res_d = (kind_q == KIND_ADD) ? OUT_FAIL : OUT_OK;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_o.load) kind_q <= kind_i;
    if (state_q == S_DONE && !ov_q) out_q <= res_q;
  end

  `DHKS_ASSERT(a_one_write, clk_i, rst_ni, !(cmd_o.wr_live && cmd_o.wr_tomb), "two writes")
  `DHKS_ASSERT(a_out_stable, clk_i, rst_ni, (ov_q && !out_ready_i) |=> $stable(out_q), "out moved")
  `DHKS_ASSERT(a_done_holds, clk_i, rst_ni, (state_q == S_DONE && ov_q) |=> (state_q == S_DONE), "done left")
  `DHKS_ASSERT(a_out_after_done, clk_i, rst_ni, $rose(ov_q) |-> $past(state_q == S_DONE), "bad out")
endmodule

// ===== hw/rtl/double_hash_key_set.sv =====
// Each input is hashed one key byte at a time (at most MAX_KEY_BYTES bytes), then probed
// slot by slot until an empty slot, a match or every slot; a full add skips the hashing.
// Throughput: one item at a time; the next input transfer is taken once the result is
// registered, so a result waiting for its transfer holds off only the next result.
// Reset is asynchronous, active low; after it a clearing pass over all 2^CAPACITY_LOG2
// slots marks every slot empty, during which no input transfer is taken.
module double_hash_key_set import dhks_pkg::*; #(
  parameter int unsigned CAPACITY_LOG2 = CapacityLog2Def,
  parameter int unsigned MAX_KEY_BYTES = MaxKeyBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // kind
  input  logic [71:0] s_axis_tdata_i,   // key_bytes[63:0], key_length[67:64]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // outcome[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [3:0] size_q;
  logic [1:0] outcome;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = {28'd0, size_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 4'd3;
    else if (psel && penable && pwrite && !paddr) size_q <= pwdata[3:0];
  end

  dhks_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .kind_i(s_axis_tuser_i), .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .outcome_o(outcome), .cmd_o(cmd), .sts_i(sts));

  dhks_datapath #(.CapacityLog2(CAPACITY_LOG2), .MaxKeyBytes(MAX_KEY_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .key_bytes_i(s_axis_tdata_i[63:0]), .key_length_i(s_axis_tdata_i[67:64]),
    .size_log2_i(size_q));

  assign m_axis_tdata_o = {6'd0, outcome};
endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dhks_pkg::*;

  localparam int unsigned DEPTH = 1 << CapacityLog2Def;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;

  class key_set_scoreboard;
    logic [63:0] keys [DEPTH];
    logic [3:0]  lens [DEPTH];
    logic [1:0]  marks [DEPTH];
    int unsigned live;
    logic [3:0]  size_reg;
    logic [1:0]  outcome_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      foreach (marks[i]) marks[i] = MARK_EMPTY;
      live = 0;
      size_reg = 4'd3;
      mismatches = 0;
      checked = 0;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function int unsigned byte_hash(logic [63:0] k, int unsigned n, int unsigned mul,
                                    int unsigned mask);
      int unsigned h;
      h = 0;
      for (int i = 0; i < n; i++) h = (h * mul + k[8*i +: 8]) & mask;
      return h;
    endfunction

    function void note_input(logic [1:0] kind, logic [63:0] key_in, logic [3:0] len_in);
      int unsigned n, lg, size, mask, pos, step, i, tomb_pos, dest;
      logic [63:0] k;
      logic [1:0] res;
      bit have_tomb, hit;
      n = (len_in > MaxKeyBytesDef) ? MaxKeyBytesDef : len_in;
      k = key_in;
      if (n < 8) k = k & ((64'd1 << (8 * n)) - 64'd1);
      lg = size_reg;
      if (lg < 3) lg = 3;
      if (lg > CapacityLog2Def) lg = CapacityLog2Def;
      size = 1 << lg;
      mask = size - 1;
      pos = byte_hash(k, n, 17, mask);
      step = ((byte_hash(k, n, 73, mask) << 1) + 1) & mask;
      have_tomb = 0;
      hit = 0;
      tomb_pos = 0;
      res = OUT_FAIL;
      if (kind == KIND_NONE) begin
        outcome_q.push_back(OUT_FAIL);
        return;
      end
      if (kind == KIND_ADD && live * 4 >= size * 3) begin
        outcome_q.push_back(OUT_FULL);
        return;
      end
      for (i = 0; i < size; i++) begin
        if (marks[pos] == MARK_EMPTY) break;
        if (marks[pos] == MARK_LIVE && lens[pos] == n && keys[pos] == k) begin
          hit = 1;
          break;
        end
        if (marks[pos] == MARK_TOMB && !have_tomb) begin
          have_tomb = 1;
          tomb_pos = pos;
        end
        pos = (pos + step) & mask;
      end
      if (hit) begin
        if (kind == KIND_ADD) res = OUT_FAIL;
        else begin
          res = OUT_OK;
          if (kind == KIND_REMOVE) begin
            marks[pos] = MARK_TOMB;
            if (live > 0) live--;
          end
        end
      end else if (kind == KIND_ADD) begin
        if (have_tomb || i < size) begin
          dest = have_tomb ? tomb_pos : pos;
          keys[dest] = k;
          lens[dest] = 4'(n);
          marks[dest] = MARK_LIVE;
          live++;
          res = OUT_OK;
        end else res = OUT_FULL;
      end
      outcome_q.push_back(res);
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endfunction

    function void check_outcome(logic [7:0] word);
      logic [1:0] want;
      if (outcome_q.size() == 0) begin
        report($sformatf("unexpected result %0h", word));
        return;
      end
      want = outcome_q.pop_front();
      checked++;
      if (word[1:0] !== want)
        report($sformatf("outcome %0d, expected %0d (result %0d)", word[1:0], want, checked));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [1:0]  s_axis_tuser_i = '0;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  double_hash_key_set u_dut (.*);

  always #5 clk_i = ~clk_i;

  key_set_scoreboard sb = new();
  int unsigned idle_mode = 0;
  int unsigned hold_off = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  logic [63:0] pool_key [64];
  logic [3:0]  pool_len [64];
  int unsigned pool_n = 8;

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_mode == 2) m_axis_tready_i <= ($urandom_range(99) >= 50);
    else if (idle_mode == 3) m_axis_tready_i <= ($urandom_range(99) >= 11);
    else m_axis_tready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_outcome(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_size(logic [3:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= {$urandom()} & 32'hFFFF_FFF0 | value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.size_reg = value;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[3:0] !== value)
      sb.report($sformatf("size register reads %0h, expected %0h", prdata[3:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(logic [1:0] kind, logic [63:0] key, logic [3:0] len);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {4'd0, len, key};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(kind, key, len);
    items_sent++;
    if ((idle_mode == 1 && $urandom_range(99) < 50) ||
        (idle_mode == 3 && $urandom_range(99) < 11)) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(logic [3:0] size_value, int unsigned count, int unsigned keys);
    int unsigned p, r;
    logic [1:0] kind;
    logic [63:0] key;
    logic [3:0] len;
    drain();
    write_size(size_value);
    pool_n = keys;
    for (int i = 0; i < pool_n; i++) begin
      pool_key[i] = {$urandom(), $urandom()};
      pool_len[i] = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    end
    for (int i = 0; i < count; i++) begin
      idle_mode = (i / 40) % 4;
      r = $urandom_range(99);
      kind = (r < 40) ? KIND_ADD : (r < 70) ? KIND_LOOKUP : (r < 95) ? KIND_REMOVE : KIND_NONE;
      if ($urandom_range(19) == 0) begin
        key = {$urandom(), $urandom()};
        len = 4'($urandom_range(15));
      end else begin
        p = $urandom_range(pool_n - 1);
        len = pool_len[p];
        key = {$urandom(), $urandom()};
        for (int b = 0; b < 8; b++) if (b < len) key[8*b +: 8] = pool_key[p][8*b +: 8];
      end
      if (i == count / 2) hold_off = 300;
      send_item(kind, key, len);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_size(4'd3);
    idle_mode = 0;
    send_item(KIND_LOOKUP, 64'd0, 4'd0);
    send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_item(KIND_LOOKUP, 64'd0, 4'd0);
    send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send_item(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12);
    send_item(KIND_ADD, 64'h0000_0000_0000_0000, 4'd8);
    send_item(KIND_ADD, 64'hDEAD_BEEF_0000_0041, 4'd1);
    send_item(KIND_LOOKUP, 64'h1234_5678_9ABC_DE41, 4'd1);
    send_item(KIND_REMOVE, 64'h0000_0000_0000_0041, 4'd1);
    send_item(KIND_REMOVE, 64'h0000_0000_0000_0041, 4'd1);
    send_item(KIND_ADD, 64'h0000_0000_0000_4241, 4'd2);
    send_item(KIND_NONE, 64'h0000_0000_0000_4241, 4'd2);
    send_item(KIND_ADD, 64'h0000_0000_0043_4241, 4'd3);
    send_item(KIND_ADD, 64'h0000_0000_4443_4241, 4'd4);
    send_item(KIND_ADD, 64'h0000_0045_4443_4241, 4'd5);
    send_item(KIND_ADD, 64'h0000_0045_4443_4241, 4'd5);
    send_item(KIND_ADD, 64'h0000_4645_4443_4241, 4'd6);
    send_item(KIND_REMOVE, 64'h0000_0000_0000_0000, 4'd0);
    send_item(KIND_ADD, 64'h0000_0000_0000_0000, 4'd0);
    drain();
    write_size(4'd0);
    send_item(KIND_LOOKUP, 64'h0000_0000_4443_4241, 4'd4);
    drain();
    write_size(4'd15);
    send_item(KIND_LOOKUP, 64'h0000_0000_4443_4241, 4'd4);
    send_item(KIND_ADD, 64'h0000_0000_0000_0077, 4'd1);
    random_phase(4'd3, 250, 12);
    random_phase(4'd4, 250, 20);
    random_phase(4'd10, 300, 64);
    random_phase(4'd5, 250, 40);
    random_phase(4'd0, 200, 10);
    random_phase(4'd15, 250, 64);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over sizes 3 to 10 and out-of-range size values;", items_sent);
    $display("checked %0d results with sender and receiver idling and a long stall.", sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dhks_pkg.sv
hw/rtl/dhks_ram.sv
hw/rtl/dhks_datapath.sv
hw/rtl/dhks_ctrl.sv
hw/rtl/double_hash_key_set.sv
bench/testbench.sv
